// File: rtl/bat_pkg.sv
// Shared types and constants for the breakpoint address table.
package bat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int ADDR_W        = 32;
   localparam int COUNT_OUT_W   = 5;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_SET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the accepted item
      logic exec;   // apply it to the table and load the result register
   } bat_cmd_type;

endpackage

// File: rtl/bat_ctrl.sv
// Controller: item sequencing and result valid.
module bat_ctrl import bat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bat_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new value this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/bat_datapath.sv
// Datapath: entry registers, parallel compare, compaction shift and result register.
module bat_datapath import bat_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  bat_cmd_type            cmd,
   input  logic [1:0]             req_operation,
   input  logic [ADDR_W-1:0]      req_address,
   output logic                   rsp_success,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   localparam logic [TABLE_ENTRIES-1:0] ALL_ONES = {TABLE_ENTRIES{1'b1}};

   logic [ADDR_W-1:0]        addr_ff [TABLE_ENTRIES];
   logic [ADDR_W-1:0]        addr_in [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] en_ff, en_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   op_type                   op_ff;
   logic [ADDR_W-1:0]        key_ff;
   logic                     success_ff, success_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;

   logic [TABLE_ENTRIES-1:0] match;
   logic [TABLE_ENTRIES-1:0] shift;
   logic                     hit;
   logic                     not_full;

   // enabled bits double as occupancy: an entry is enabled exactly when it is stored
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i] = en_ff[i] && (addr_ff[i] == key_ff);
      end
   end

   // delete moves every entry at or above the lowest match down one place
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         shift[i] = |(match & (ALL_ONES >> (TABLE_ENTRIES - 1 - i)));
      end
   end

   assign hit      = |match;
   assign not_full = (count_ff < CNT_W'(TABLE_ENTRIES));

   always_comb begin
      en_in      = en_ff;
      count_in   = count_ff;
      success_in = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         addr_in[i] = addr_ff[i];
      end
      unique case (op_ff)
         OP_CHECK: begin
            success_in = hit;
         end
         OP_SET: begin
            success_in = hit || not_full;
            if (!hit && not_full) begin
               for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (count_ff == CNT_W'(i)) begin
                     addr_in[i] = key_ff;
                     en_in[i]   = 1'b1;
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            success_in = hit;
            if (hit) begin
               for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
                  if (shift[i]) begin
                     addr_in[i] = addr_ff[i + 1];
                     en_in[i]   = en_ff[i + 1];
                  end
               end
               // top slot has nothing above it to pull down
               if (shift[TABLE_ENTRIES-1]) begin
                  en_in[TABLE_ENTRIES-1] = 1'b0;
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            success_in = 1'b1;
            en_in      = '0;
            count_in   = '0;
         end
         default: begin
            success_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         en_ff    <= en_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            addr_ff[i] <= addr_in[i];
         end
         success_ff   <= success_in;
         rsp_count_ff <= COUNT_OUT_W'(count_in);
      end
      if (cmd.load) begin
         op_ff  <= op_type'(req_operation);
         key_ff <= req_address;
      end
   end

   assign rsp_success     = success_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// File: rtl/breakpoint_address_table_unit.sv
// Top level of the breakpoint address table.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_operation, req_address
//   rsp       out        rsp_valid / rsp_ready  rsp_success, rsp_entry_count
//
// Each item is first captured, then goes through the 16-way compare and
// the table update, which writes the result register.
// The next item is taken while a result still waits in the result register;
// a stalled rsp side holds the update step until that register frees up.
// Reset empties the table at once (enabled bits and count); no clearing pass.
module breakpoint_address_table_unit import bat_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  logic [ADDR_W-1:0]      req_address,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_success,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   bat_cmd_type cmd;

   bat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bat_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .rsp_success     (rsp_success),
      .rsp_entry_count (rsp_entry_count)
   );

   // one item in flight: an accepted item blocks the input until it is applied
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("table update produced no result");

   a_no_load_in_exec: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec && cmd.load))
      else $error("capture and update in the same cycle");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for breakpoint_address_table_unit: directed table, then random traffic.
module tb;
   import bat_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int POOL_SIZE    = 24;
   localparam int N_DIR        = 15;

   typedef struct packed {
      logic                   success;
      logic [COUNT_OUT_W-1:0] entry_count;
   } bp_result_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] stride;
      logic [4:0]        reps;
      logic              typed;
      bp_result_type     known_res;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   op_type                 req_operation;
   logic [ADDR_W-1:0]      req_address;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_success;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   // predictor copy of the table
   logic [ADDR_W-1:0] bp_addr [TABLE_ENTRIES];
   logic              bp_en   [TABLE_ENTRIES];
   int                pred_count;

   bp_result_type pending_results [$];
   int fail_count, n_items, n_results, n_hits, n_full, n_absent, n_clears;
   int req_idle_pct, rsp_idle_pct;
   logic hold_req, hold_taken;

   // typed-in results only where the outcome is obvious
   dir_row_type directed_rows [N_DIR] = '{
      '{OP_CHECK,  32'h0000_0000, 32'h0, 5'd1,  1'b1, '{1'b0, 5'd0}},   // empty after reset
      '{OP_DELETE, 32'h5A5A_5A5A, 32'h0, 5'd1,  1'b1, '{1'b0, 5'd0}},   // delete of absent
      '{OP_SET,    32'hFFFF_FFFF, 32'h0, 5'd1,  1'b1, '{1'b1, 5'd1}},
      '{OP_SET,    32'hFFFF_FFFF, 32'h0, 5'd1,  1'b1, '{1'b1, 5'd1}},   // duplicate set
      '{OP_CHECK,  32'hFFFF_FFFF, 32'h0, 5'd1,  1'b0, '{1'b0, 5'd0}},
      '{OP_SET,    32'h0000_0000, 32'h0, 5'd1,  1'b0, '{1'b0, 5'd0}},
      '{OP_SET,    32'h1000_0000, 32'h0100_0003, 5'd14, 1'b0, '{1'b0, 5'd0}},
      '{OP_SET,    32'h5555_5555, 32'h0, 5'd1,  1'b1, '{1'b0, 5'd16}},  // table full
      '{OP_SET,    32'h0000_0000, 32'h0, 5'd1,  1'b1, '{1'b1, 5'd16}},  // duplicate set when full
      '{OP_DELETE, 32'hFFFF_FFFF, 32'h0, 5'd1,  1'b1, '{1'b1, 5'd15}},  // shifts everything down
      '{OP_CHECK,  32'h1D00_0027, 32'h0, 5'd1,  1'b0, '{1'b0, 5'd0}},
      '{OP_DELETE, 32'h1D00_0027, 32'h0, 5'd1,  1'b0, '{1'b0, 5'd0}},
      '{OP_CHECK,  32'h1D00_0027, 32'h0, 5'd1,  1'b0, '{1'b0, 5'd0}},   // vacated slot ignored
      '{OP_CLEAR,  32'hA5A5_A5A5, 32'h0, 5'd1,  1'b1, '{1'b1, 5'd0}},
      '{OP_CHECK,  32'h0000_0000, 32'h0, 5'd1,  1'b1, '{1'b0, 5'd0}}
   };

   breakpoint_address_table_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_entry_count (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   function automatic bp_result_type apply_breakpoint_op(op_type op, logic [ADDR_W-1:0] addr);
      bp_result_type res;
      int            slot;
      res.success = 1'b0;
      slot = -1;
      for (int i = 0; i < pred_count; i++)
         if (slot < 0 && bp_addr[i] == addr) slot = i;
      case (op)
         OP_CHECK: begin
            for (int i = 0; i < pred_count; i++)
               if (bp_en[i] && bp_addr[i] == addr) res.success = 1'b1;
         end
         OP_SET: begin
            if (slot >= 0) begin
               bp_en[slot] = 1'b1;
               res.success = 1'b1;
            end else if (pred_count < TABLE_ENTRIES) begin
               bp_addr[pred_count] = addr;
               bp_en[pred_count]   = 1'b1;
               pred_count++;
               res.success = 1'b1;
            end
         end
         OP_DELETE: begin
            if (slot >= 0) begin
               for (int i = slot; i + 1 < pred_count; i++) begin
                  bp_addr[i] = bp_addr[i+1];
                  bp_en[i]   = bp_en[i+1];
               end
               pred_count--;
               bp_en[pred_count] = 1'b0;
               res.success = 1'b1;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               bp_addr[i] = '0;
               bp_en[i]   = 1'b0;
            end
            pred_count = 0;
            res.success = 1'b1;
         end
      endcase
      res.entry_count = COUNT_OUT_W'(pred_count);
      return res;
   endfunction

   // Called at a clock edge; returns at the edge where the item is taken, valid still high.
   task automatic send_item(input op_type op, input logic [ADDR_W-1:0] addr,
                            input logic typed, input bp_result_type typed_res);
      bp_result_type res;
      int            gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_address   <= addr;
      do @(posedge clock); while (!req_ready);
      res = apply_breakpoint_op(op, addr);
      n_items++;
      if (op == OP_CHECK && res.success) n_hits++;
      if (op == OP_SET && !res.success) n_full++;
      if (op == OP_DELETE && !res.success) n_absent++;
      if (op == OP_CLEAR) n_clears++;
      pending_results.push_back(typed ? typed_res : res);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic random_phase(input int count, input int snd_pct, input int rcv_pct,
                               input logic with_hold);
      logic [ADDR_W-1:0] pool [POOL_SIZE];
      op_type            op;
      logic [ADDR_W-1:0] addr;
      int                pick;
      req_idle_pct = snd_pct;
      rsp_idle_pct = rcv_pct;
      if (with_hold) hold_req = 1'b1;
      foreach (pool[i]) pool[i] = $urandom();
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 38)      op = OP_SET;
         else if (pick < 74) op = OP_CHECK;
         else if (pick < 97) op = OP_DELETE;
         else                op = OP_CLEAR;
         // mostly a small pool so sets, hits and deletes meet the same addresses
         if ($urandom_range(99) < 85) addr = pool[$urandom_range(POOL_SIZE-1)];
         else                          addr = $urandom();
         send_item(op, addr, 1'b0, '0);
      end
      drain();
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      rsp_ready  = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      bp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected item: success=%0b count=%0d", rsp_success, rsp_entry_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_success !== want.success || rsp_entry_count !== want.entry_count) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch at item %0d: expected success=%0b count=%0d, got %0b %0d",
                           n_results, want.success, want.entry_count,
                           rsp_success, rsp_entry_count);
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_CHECK;
      req_address   = '0;
      req_idle_pct  = 22;
      rsp_idle_pct  = 79;
      hold_req      = 1'b0;
      fail_count = 0; n_items = 0; n_results = 0;
      n_hits = 0; n_full = 0; n_absent = 0; n_clears = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         bp_addr[i] = '0;
         bp_en[i]   = 1'b0;
      end
      pred_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIR; r++)
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_item(directed_rows[r].op,
                      directed_rows[r].addr + k * directed_rows[r].stride,
                      directed_rows[r].typed, directed_rows[r].known_res);
      drain();

      random_phase(130, 22, 79, 1'b0);
      random_phase(130, 79, 22, 1'b0);
      random_phase(140, 0, 0, 1'b1);

      repeat (6) @(posedge clock);
      $display("Sent %0d items, checked %0d results, %0d mismatches.",
               n_items, n_results, fail_count);
      $display("Seen: %0d check hits, %0d sets refused on a full table,",
               n_hits, n_full);
      $display("      %0d absent deletes, %0d clears.", n_absent, n_clears);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/bat_pkg.sv
rtl/bat_ctrl.sv
rtl/bat_datapath.sv
rtl/breakpoint_address_table_unit.sv
tb/tb.sv
